>>> hdl/assert_macros.svh
// assertion macros used by the top level of the motor positioner
// depends on a clock named clk and an active-low reset named arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every clock edge outside reset
`define PFMP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// overlapping implication, checked outside reset
`define PFMP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PFMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pfmp_pkg.sv
// shared types and codes for the potentiometer feedback motor positioner
// no dependencies; used by the controller, the datapath and the top level
`default_nettype none

package pfmp_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int DUTY_W     = 8;
	localparam int GRAN_W     = 10;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_POS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JERK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAST     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW     = 3'd6;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] MIN_POS_RST = 10'd0;
	localparam logic [CFG_DATA_W-1:0] MAX_POS_RST = 10'd1023;
	localparam logic [GRAN_W-1:0]     GRAN_RST    = 10'd8;
	localparam logic [DUTY_W-1:0]     JERK_RST    = 8'd255;
	localparam logic [DUTY_W-1:0]     FAST_RST    = 8'd200;
	localparam logic [DUTY_W-1:0]     MEDIUM_RST  = 8'd150;
	localparam logic [DUTY_W-1:0]     SLOW_RST    = 8'd100;

	// command field
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_MOVE = 1'b1;

	// drive direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// move status codes
	localparam logic [1:0] ST_MOVING  = 2'd0;
	localparam logic [1:0] ST_IDLE    = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// "more than k slices" is the same as distance >= (k+1) * granularity
	localparam int TH_MOVE   = 2;
	localparam int TH_MEDIUM = 6;
	localparam int TH_FAST   = 16;
	localparam int TH_JERK   = 26;

	// width that holds 26 * 1023
	localparam int TH_MIN_W = 15;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic calc;
		logic cmp;
		logic commit;
	} pfmp_cmd_t;

endpackage

`default_nettype wire

>>> hdl/pot_feedback_motor_positioner.sv
// Potentiometer feedback motor positioner, top level; depends on pfmp_pkg, pfmp_ctrl,
// pfmp_datapath and assert_macros.svh. Each input item (a tick with a new sample, or a move
// request with target and sample) gives exactly one result: direction, applied duty and move
// status. Items are taken one at a time: the capture happens at the accepting edge, then the
// distance, compare and commit registers follow in that order; the commit loads the result
// into the single output register and waits while it holds an untaken result. in_stall is
// low only while the controller is idle, so a new item is taken only after the last result
// is committed. Slice counts are never divided out: "more than k slices" is checked as
// distance against a constant multiple of granularity, and zero granularity acts as one.
// The configuration port is always ready; write it only while no item is in flight.
`default_nettype none
`include "assert_macros.svh"

module pot_feedback_motor_positioner import pfmp_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration writes
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   command,
	input  wire logic [SAMPLE_BITS-1:0] target_position,
	input  wire logic [SAMPLE_BITS-1:0] pot_sample,
	// result items
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [1:0]                  drive_direction,
	output logic [DUTY_W-1:0]           drive_duty,
	output logic [1:0]                  move_status
);

	pfmp_cmd_t cmd;
	logic      cfg_we;
	logic      res_stopped;
	logic      res_moving;
	logic      drive_off;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencing
	pfmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// registers and compare logic
	pfmp_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.command         (command),
		.target_position (target_position),
		.pot_sample      (pot_sample),
		.drive_direction (drive_direction),
		.drive_duty      (drive_duty),
		.move_status     (move_status)
	);

	// result classification for the checks below
	assign res_stopped = (move_status == ST_REFUSED) || (move_status == ST_IDLE);
	assign res_moving  = (move_status == ST_MOVING);
	assign drive_off   = (drive_direction == DIR_STOP);

	// one item at a time: an accepted item holds off the next
	`PFMP_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "item accepted while busy")
	// a refused or idle result never drives the motor
	`PFMP_ASSERT_IMP(a_refused_stop, out_valid && res_stopped, drive_off, "drive without move")
	// a moving result always drives the motor
	`PFMP_ASSERT_IMP(a_moving_drive, out_valid && res_moving, !drive_off, "moving, drive stopped")

endmodule

`default_nettype wire

>>> hdl/pfmp_ctrl.sv
// sequencing controller of the motor positioner: one item at a time
// depends on pfmp_pkg; drives the datapath through pfmp_cmd_t
`default_nettype none

module pfmp_ctrl import pfmp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	output pfmp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_CMP,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit_ok;

	// result can go out when the output register is empty or being emptied
	assign commit_ok = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);

	// command decode
	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.calc   = (state_q == S_CALC);
		cmd.cmp    = (state_q == S_CMP);
		cmd.commit = commit_ok;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CALC;
				end
				S_CALC: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit_ok) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit_ok) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/pfmp_datapath.sv
// datapath of the motor positioner: config registers, move state, distance compare, result
// depends on pfmp_pkg; stepped by the commands of pfmp_ctrl
`default_nettype none

module pfmp_datapath import pfmp_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pfmp_cmd_t              cmd,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   command,
	input  wire logic [SAMPLE_BITS-1:0] target_position,
	input  wire logic [SAMPLE_BITS-1:0] pot_sample,
	output logic [1:0]                  drive_direction,
	output logic [DUTY_W-1:0]           drive_duty,
	output logic [1:0]                  move_status
);

	localparam int SB = SAMPLE_BITS;
	localparam int TW = (SB > TH_MIN_W) ? SB : TH_MIN_W;

	// configuration registers
	logic [SB-1:0]     min_pos_q, max_pos_q;
	logic [GRAN_W-1:0] gran_q;
	logic [DUTY_W-1:0] jerk_q, fast_q, medium_q, slow_q;

	// move state
	logic              moving_q, down_q;
	logic [SB-1:0]     goal_q, prev_q;
	logic [DUTY_W-1:0] duty_q;

	// item stages
	logic              cmd_s1;
	logic [SB-1:0]     tgt_s1, smp_s1;
	logic [SB-1:0]     dist_s2, step_s2;
	logic              up_s2, ahead_s2, range_s2;
	logic [GRAN_W-1:0] geff_s2;
	logic [TW-1:0]     th_move_s2, th_med_s2, th_fast_s2, th_jerk_s2;
	logic              gt1_s3, gt5_s3, gt15_s3, gt25_s3, stall_s3;

	// result payload
	logic [1:0]        dir_q, status_q;
	logic [DUTY_W-1:0] out_duty_q;

	// next-state values at commit
	logic              mv_n, dn_n, start;
	logic [SB-1:0]     goal_n, prev_n;
	logic [DUTY_W-1:0] duty_n;
	logic [1:0]        st_n;
	logic [GRAN_W-1:0] geff;

	// zero granularity counts as one
	assign geff = (gran_q == '0) ? GRAN_W'(1) : gran_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pos_q <= SB'(MIN_POS_RST);
			max_pos_q <= SB'(MAX_POS_RST);
			gran_q    <= GRAN_RST;
			jerk_q    <= JERK_RST;
			fast_q    <= FAST_RST;
			medium_q  <= MEDIUM_RST;
			slow_q    <= SLOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_POS: min_pos_q <= SB'(cfg_data);
				REG_MAX_POS: max_pos_q <= SB'(cfg_data);
				REG_GRAN:    gran_q    <= cfg_data;
				REG_JERK:    jerk_q    <= cfg_data[DUTY_W-1:0];
				REG_FAST:    fast_q    <= cfg_data[DUTY_W-1:0];
				REG_MEDIUM:  medium_q  <= cfg_data[DUTY_W-1:0];
				REG_SLOW:    slow_q    <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: capture the item; a tick measures against the stored goal
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_s1 <= command;
			tgt_s1 <= (command == CMD_MOVE) ? target_position : goal_q;
			smp_s1 <= pot_sample;
		end
	end

	// stage 2: distances, direction, range and slice thresholds
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			dist_s2    <= (tgt_s1 > smp_s1) ? tgt_s1 - smp_s1 : smp_s1 - tgt_s1;
			step_s2    <= (smp_s1 > prev_q) ? smp_s1 - prev_q : prev_q - smp_s1;
			up_s2      <= tgt_s1 > smp_s1;
			ahead_s2   <= down_q ? (tgt_s1 < smp_s1) : (tgt_s1 > smp_s1);
			range_s2   <= (tgt_s1 >= min_pos_q) && (tgt_s1 <= max_pos_q);
			geff_s2    <= geff;
			th_move_s2 <= TW'(geff) * TW'(TH_MOVE);
			th_med_s2  <= TW'(geff) * TW'(TH_MEDIUM);
			th_fast_s2 <= TW'(geff) * TW'(TH_FAST);
			th_jerk_s2 <= TW'(geff) * TW'(TH_JERK);
		end
	end

	// stage 3: slice and stall compares
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			gt1_s3   <= TW'(dist_s2) >= th_move_s2;
			gt5_s3   <= TW'(dist_s2) >= th_med_s2;
			gt15_s3  <= TW'(dist_s2) >= th_fast_s2;
			gt25_s3  <= TW'(dist_s2) >= th_jerk_s2;
			stall_s3 <= TW'(step_s2) < TW'(geff_s2);
		end
	end

	// decision for the item
	always_comb begin
		mv_n   = moving_q;
		dn_n   = down_q;
		goal_n = goal_q;
		prev_n = prev_q;
		duty_n = duty_q;
		st_n   = ST_IDLE;
		start  = 1'b0;
		priority if (cmd_s1 == CMD_MOVE) begin
			start = 1'b1;
		end else if (!moving_q) begin
			st_n = ST_IDLE;
		end else if (ahead_s2 && gt1_s3) begin
			// keep going, duty from remaining slices or stall
			priority if (gt25_s3 || stall_s3) begin
				duty_n = jerk_q;
			end else if (gt15_s3) begin
				duty_n = fast_q;
			end else if (gt5_s3) begin
				duty_n = medium_q;
			end else begin
				duty_n = slow_q;
			end
			prev_n = smp_s1;
			st_n   = ST_MOVING;
		end else if (gt1_s3) begin
			// overshoot with distance left: restart toward the goal
			start = 1'b1;
		end else begin
			mv_n = 1'b0;
			st_n = ST_IDLE;
		end
		// new move from the captured target and sample
		if (start) begin
			if (!range_s2 || !gt1_s3) begin
				mv_n = 1'b0;
				st_n = ST_REFUSED;
			end else begin
				mv_n   = 1'b1;
				dn_n   = !up_s2;
				goal_n = tgt_s1;
				prev_n = smp_s1;
				duty_n = jerk_q;
				st_n   = ST_MOVING;
			end
		end
	end

	// move state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q <= 1'b0;
			down_q   <= 1'b0;
			goal_q   <= '0;
			prev_q   <= '0;
			duty_q   <= '0;
		end else if (cmd.commit) begin
			moving_q <= mv_n;
			down_q   <= dn_n;
			goal_q   <= goal_n;
			prev_q   <= prev_n;
			duty_q   <= duty_n;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			dir_q      <= mv_n ? (dn_n ? DIR_DOWN : DIR_UP) : DIR_STOP;
			out_duty_q <= duty_n;
			status_q   <= st_n;
		end
	end

	assign drive_direction = dir_q;
	assign drive_duty      = out_duty_q;
	assign move_status     = status_q;

endmodule

`default_nettype wire
